### rtl/core/mfw_pkg.sv
// mfw_pkg: shared types, constants and coefficient functions for the
// mitchell filter weight pipeline. No dependencies.
package mfw_pkg;

  // pipeline depth: six stages per axis, four for the product and scaling
  localparam int AXIS_STAGES = 6;
  localparam int NUM_STAGES  = 10;

  // configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_WIDTH_X = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_WIDTH_Y = 4'd3;

  localparam logic signed [15:0] COEF_RESET = 16'sd5461;
  localparam logic [23:0]        INV_RESET  = 24'd32768;

  // output scaling: divide the q28 product by 36 * 2^12, round half away from zero
  localparam logic [51:0] ROUND_HALF = 52'd73728;
  localparam logic [51:0] THR_POS    = 52'd154618748928;
  localparam logic [51:0] THR_NEG    = 52'd154618896384;
  localparam logic [26:0] RECIP_36   = 27'd119304648;
  localparam logic [20:0] Q_LIMIT    = 21'd1048576;
  localparam logic signed [20:0] WEIGHT_MAX = 21'sd1048575;
  localparam logic signed [20:0] WEIGHT_MIN = -21'sd1048576;

  typedef logic signed [21:0] coef_t;

  // cubic coefficients, highest power first, q14
  typedef struct packed {
    coef_t c3;
    coef_t c2;
    coef_t c1;
    coef_t c0;
  } cubic_coef_t;

  function automatic cubic_coef_t inner_coefs(input logic signed [15:0] b,
                                              input logic signed [15:0] c);
    logic signed [23:0] bx;
    logic signed [23:0] cx;
    cubic_coef_t r;
    bx = 24'(b);
    cx = 24'(c);
    r.c3 = 22'(24'sd196608 - 24'sd9 * bx - 24'sd6 * cx);
    r.c2 = 22'(-24'sd294912 + 24'sd12 * bx + 24'sd6 * cx);
    r.c1 = '0;
    r.c0 = 22'(24'sd98304 - 24'sd2 * bx);
    return r;
  endfunction

  function automatic cubic_coef_t outer_coefs(input logic signed [15:0] b,
                                              input logic signed [15:0] c);
    logic signed [23:0] bx;
    logic signed [23:0] cx;
    cubic_coef_t r;
    bx = 24'(b);
    cx = 24'(c);
    r.c3 = 22'(-bx - 24'sd6 * cx);
    r.c2 = 22'(24'sd6 * bx + 24'sd30 * cx);
    r.c1 = 22'(-24'sd12 * bx - 24'sd48 * cx);
    r.c0 = 22'(24'sd8 * bx + 24'sd24 * cx);
    return r;
  endfunction

endpackage

### rtl/core/mfw_axis.sv
// mfw_axis: one axis of the filter, scaled distance and horner cubic over
// six pipeline stages. Depends on mfw_pkg; stage enables come from the top.
module mfw_axis import mfw_pkg::*; (
  input  logic                     clk,
  input  logic [AXIS_STAGES-1:0]   en,
  input  logic signed [31:0]       off,
  input  logic [23:0]              inv,
  input  cubic_coef_t              inner,
  input  cubic_coef_t              outer,
  output logic signed [25:0]       w
);

  logic [31:0]        mag_r;
  logic [55:0]        p_r;
  logic [17:0]        d2_r, d3_r;
  logic               in2_r, in3_r, in4_r;
  logic               z2_r, z3_r, z4_r;
  logic signed [44:0] pr2_r, pr3_r, pr4_r;
  logic signed [25:0] w_r;

  logic               inner_w, zero_w;
  logic [17:0]        d_w;
  coef_t              c3_w, c2_w, c1_w, c0_w;
  logic signed [25:0] acc3_w, acc4_w, acc5_w;

  // round half up back to q14
  function automatic logic signed [25:0] rnd(input logic signed [44:0] v);
    logic signed [44:0] t;
    t = v + 45'sd32768;
    return t[41:16];
  endfunction

  always_comb begin
    inner_w = (p_r[55:32] == '0) && (!p_r[31] || (p_r[30:0] == '0));
    zero_w  = (p_r[55:33] != '0) || (p_r[32] && (p_r[31:0] != '0));
    d_w     = p_r[32:15];
    c3_w    = inner_w ? inner.c3 : outer.c3;
    c2_w    = in2_r ? inner.c2 : outer.c2;
    c1_w    = in3_r ? inner.c1 : outer.c1;
    c0_w    = in4_r ? inner.c0 : outer.c0;
    acc3_w  = 26'(c3_w);
    acc4_w  = rnd(pr2_r) + 26'(c2_w);
    acc5_w  = rnd(pr3_r) + 26'(c1_w);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mag_r <= off[31] ? 32'(-off) : 32'(off);
    end
    if (en[1]) begin
      p_r <= 56'(mag_r) * 56'(inv);
    end
    if (en[2]) begin
      d2_r  <= d_w;
      in2_r <= inner_w;
      z2_r  <= zero_w;
      pr2_r <= 45'(acc3_w) * 45'($signed({1'b0, d_w}));
    end
    if (en[3]) begin
      d3_r  <= d2_r;
      in3_r <= in2_r;
      z3_r  <= z2_r;
      pr3_r <= 45'(acc4_w) * 45'($signed({1'b0, d2_r}));
    end
    if (en[4]) begin
      in4_r <= in3_r;
      z4_r  <= z3_r;
      pr4_r <= 45'(acc5_w) * 45'($signed({1'b0, d3_r}));
    end
    if (en[5]) begin
      w_r <= z4_r ? '0 : rnd(pr4_r) + 26'(c0_w);
    end
  end

  assign w = w_r;

endmodule

### rtl/core/mitchell_filter_weight.sv
// mitchell_filter_weight: separable mitchell-netravali filter weight, top level.
// Depends on mfw_pkg and mfw_axis.
//
//   channel | direction | handshake         | payload
//   in      | input     | in_valid/in_stall | in_x_offset, in_y_offset
//   out     | output    | out_valid/out_stall | out_weight
//   cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one word per cycle sustained while out_stall is low, through the ten-stage
// pipeline (axis cubics, product, scaling).
// synchronous active-low reset clears stage valids and loads register defaults.
// a stall on out holds the output register; empty stages still fill, so
// in_stall rises only when every stage holds a word.
// cfg_ready is always high; writes to unused indexes are dropped.
module mitchell_filter_weight import mfw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    in_x_offset,
  input  logic signed [31:0]    in_y_offset,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [20:0]    out_weight,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [23:0]           cfg_data
);

  logic signed [15:0] coef_b_r, coef_c_r;
  logic [23:0]        inv_x_r, inv_y_r;

  logic [NUM_STAGES-1:0] v_r, v_nxt, en_w;

  cubic_coef_t        inner_w, outer_w;
  logic signed [25:0] wx_w, wy_w;
  logic [25:0]        ax_w, ay_w;

  logic [51:0]        wm_r;
  logic               sg6_r, sg7_r, sg8_r;
  logic [25:0]        n_r;
  logic               sat7_r, sat8_r;
  logic [52:0]        qm_r;
  logic signed [20:0] out_weight_r;

  logic [51:0]        sum_w;
  logic [20:0]        q_w;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_b_r <= COEF_RESET;
      coef_c_r <= COEF_RESET;
      inv_x_r  <= INV_RESET;
      inv_y_r  <= INV_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COEF_B:      coef_b_r <= cfg_data[15:0];
        REG_COEF_C:      coef_c_r <= cfg_data[15:0];
        REG_INV_WIDTH_X: inv_x_r  <= cfg_data;
        REG_INV_WIDTH_Y: inv_y_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when empty or when the next one moves
  always_comb begin
    en_w[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en_w[k] = !v_r[k] || en_w[k+1];
    end
    v_nxt[0] = en_w[0] ? in_valid : v_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      v_nxt[k] = en_w[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall = !en_w[0];

  always_comb begin
    inner_w = inner_coefs(coef_b_r, coef_c_r);
    outer_w = outer_coefs(coef_b_r, coef_c_r);
  end

  mfw_axis u_axis_x (
    .clk   (clk),
    .en    (en_w[AXIS_STAGES-1:0]),
    .off   (in_x_offset),
    .inv   (inv_x_r),
    .inner (inner_w),
    .outer (outer_w),
    .w     (wx_w)
  );

  mfw_axis u_axis_y (
    .clk   (clk),
    .en    (en_w[AXIS_STAGES-1:0]),
    .off   (in_y_offset),
    .inv   (inv_y_r),
    .inner (inner_w),
    .outer (outer_w),
    .w     (wy_w)
  );

  always_comb begin
    ax_w  = wx_w[25] ? 26'(-wx_w) : 26'(wx_w);
    ay_w  = wy_w[25] ? 26'(-wy_w) : 26'(wy_w);
    sum_w = wm_r + ROUND_HALF;
    q_w   = qm_r[52:32];
  end

  // magnitude product, round, divide by 36 * 2^12 with a reciprocal multiply, then saturate and apply the sign
  always_ff @(posedge clk) begin
    if (en_w[6]) begin
      wm_r  <= 52'(ax_w) * 52'(ay_w);
      sg6_r <= wx_w[25] ^ wy_w[25];
    end
    if (en_w[7]) begin
      n_r    <= sum_w[37:12];
      sat7_r <= sg6_r ? (wm_r >= THR_NEG) : (wm_r >= THR_POS);
      sg7_r  <= sg6_r;
    end
    if (en_w[8]) begin
      qm_r   <= 53'(n_r) * 53'(RECIP_36);
      sat8_r <= sat7_r;
      sg8_r  <= sg7_r;
    end
    if (en_w[9]) begin
      if (sat8_r) begin
        out_weight_r <= sg8_r ? WEIGHT_MIN : WEIGHT_MAX;
      end else begin
        out_weight_r <= sg8_r ? 21'(-q_w) : 21'(q_w);
      end
    end
  end

  assign out_valid  = v_r[NUM_STAGES-1];
  assign out_weight = out_weight_r;

  // input is held off only when the whole pipeline is full and blocked
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v_r == '1) && out_stall)
    else $error("input stalled with room in the pipeline");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v_r[0])
    else $error("accepted word did not enter the first stage");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[8] && !sat8_r |-> (q_w <= Q_LIMIT))
    else $error("unsaturated quotient out of range");

  a_cfg_b: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && (cfg_index == REG_COEF_B) |=> coef_b_r == $past(cfg_data[15:0]))
    else $error("coef_b write lost");

endmodule
